// File: design/dse_pkg.sv
// Shared constants for the DFA state equivalence unit.
// Holds field widths, defaults, operation codes and register indexes; no dependencies.
package dse_pkg;

    // Default sizing, handed to the top level parameters
    localparam int MAX_STATES_DEF  = 16;
    localparam int MAX_SYMBOLS_DEF = 8;
    // Results carry a 4-bit state number, so at most this many states take part
    localparam int OUT_LIMIT       = 16;

    // Item field widths
    localparam int FUNC_W     = 2;
    localparam int STATE_W    = 4;
    localparam int SYMBOL_W   = 3;
    localparam int S_TDATA_W  = 16;
    localparam int M_TDATA_W  = 8;

    // Operation codes carried in s_tuser
    localparam logic [FUNC_W-1:0] FUNC_LOAD_TRANS = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_LOAD_ACC   = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_START      = 2'd2;

    // Configuration port
    localparam int CFG_ADDR_W      = 1;
    localparam int CFG_DATA_W      = 5;
    localparam int STATE_COUNT_W   = 5;
    localparam int SYMBOL_COUNT_W  = 4;
    localparam logic [CFG_ADDR_W-1:0] REG_STATE_COUNT  = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] REG_SYMBOL_COUNT = 1'b1;

    localparam logic [STATE_COUNT_W-1:0]  STATE_COUNT_RESET  = 5'd16;
    localparam logic [SYMBOL_COUNT_W-1:0] SYMBOL_COUNT_RESET = 4'd8;

endpackage

// File: design/dse_trans_mem.sv
// Transition table memory: one write port, two registered read ports.
// Standalone; no package dependencies.
module dse_trans_mem #(
    parameter int ADDR_W = 7,
    parameter int DEPTH  = 128,
    parameter int DATA_W = 4
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] wa,
    input  logic [DATA_W-1:0] wd,
    input  logic [ADDR_W-1:0] ra0,
    input  logic [ADDR_W-1:0] ra1,
    output logic [DATA_W-1:0] rd0,
    output logic [DATA_W-1:0] rd1
);

    logic [DATA_W-1:0] mem_reg [0:DEPTH-1];
    logic [DATA_W-1:0] rd0_reg;
    logic [DATA_W-1:0] rd1_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[wa] <= wd;
        end
        rd0_reg <= mem_reg[ra0];
        rd1_reg <= mem_reg[ra1];
    end

    assign rd0 = rd0_reg;
    assign rd1 = rd1_reg;

endmodule

// File: design/dse_row_mem.sv
// Distinguishability row memory: one write port, one registered read port.
// Standalone; no package dependencies.
module dse_row_mem #(
    parameter int ADDR_W = 4,
    parameter int DEPTH  = 16,
    parameter int DATA_W = 16
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] wa,
    input  logic [DATA_W-1:0] wd,
    input  logic [ADDR_W-1:0] ra,
    output logic [DATA_W-1:0] rd
);

    logic [DATA_W-1:0] mem_reg [0:DEPTH-1];
    logic [DATA_W-1:0] rd_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[wa] <= wd;
        end
        rd_reg <= mem_reg[ra];
    end

    assign rd = rd_reg;

endmodule

// File: design/dfa_state_equivalence_unit.sv
// DFA state equivalence unit (table filling), built on dse_pkg, dse_trans_mem and
// dse_row_mem. Load items (s_tuser = load transition or load accepting flag) are
// taken one per cycle while the unit is idle and give no result. A start item
// clamps state_count to 1..min(MAX_STATES,16) and symbol_count to 1..MAX_SYMBOLS,
// then works alone until its last result is taken: it writes the initial rows
// (pairs whose accepting flags differ), then whole passes run over the lower
// triangle of the pair table until a pass marks nothing. Each pass reads, works
// and writes back each of rows 1..n-1, skips each pair already marked and, for
// every pair still unmarked, steps through the symbols until one marks it: issue
// the paired transition reads, issue the read of the successor pair's row and
// test it, all through synchronous memories with registered reads. Last, one
// result per active state leaves, each held until m_tready takes it, giving the
// least-numbered equivalent state, with m_tlast on the highest active state.
// s_tready stays low during reset. Only the lower triangle is stored: row p holds
// bit q for q < p. A row under work sits in a working register and is written
// back at its end; lookups of that row are forwarded from the register.
module dfa_state_equivalence_unit #(
    parameter int MAX_STATES  = dse_pkg::MAX_STATES_DEF,
    parameter int MAX_SYMBOLS = dse_pkg::MAX_SYMBOLS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // Configuration write port
    input  logic                                cfg_we,
    input  logic [dse_pkg::CFG_ADDR_W-1:0]      cfg_addr,
    input  logic [dse_pkg::CFG_DATA_W-1:0]      cfg_wdata,
    // Input channel
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // tdata, lowest bit up: state_index[3:0], symbol_index[6:4],
    // next_state[10:7], accepting[11], zero fill [15:12]
    input  logic [dse_pkg::S_TDATA_W-1:0]       s_tdata,
    // tuser: func[1:0]
    input  logic [dse_pkg::FUNC_W-1:0]          s_tuser,
    // Result channel
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // tdata, lowest bit up: state_number[3:0], representative[7:4]
    output logic [dse_pkg::M_TDATA_W-1:0]       m_tdata,
    output logic                                m_tlast
);

    localparam int STATE_LIMIT = (MAX_STATES < dse_pkg::OUT_LIMIT) ?
                                 MAX_STATES : dse_pkg::OUT_LIMIT;
    localparam int ROW_W  = $clog2(STATE_LIMIT);
    localparam int CNT_W  = $clog2(STATE_LIMIT + 1);
    localparam int ST_W   = $clog2(MAX_STATES);
    localparam int SYM_W  = (MAX_SYMBOLS > 1) ? $clog2(MAX_SYMBOLS) : 1;
    localparam int SYMC_W = $clog2(MAX_SYMBOLS + 1);
    localparam int TA_W   = ST_W + SYM_W;
    localparam int T_DEPTH = MAX_STATES * (2 ** SYM_W);
    localparam int SW     = dse_pkg::STATE_W;

    // Sequencer states
    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_INIT     = 4'd1;
    localparam logic [3:0] S_ROW_RD   = 4'd2;
    localparam logic [3:0] S_ROW_WT   = 4'd3;
    localparam logic [3:0] S_SYM_RD   = 4'd4;
    localparam logic [3:0] S_SYM_WT   = 4'd5;
    localparam logic [3:0] S_DIST_CHK = 4'd6;
    localparam logic [3:0] S_ROW_WR   = 4'd7;
    localparam logic [3:0] S_OUT_RD   = 4'd8;
    localparam logic [3:0] S_OUT_WT   = 4'd9;
    localparam logic [3:0] S_OUT_HOLD = 4'd10;

    // Input fields
    logic [dse_pkg::FUNC_W-1:0]   in_func;
    logic [SW-1:0]                in_state;
    logic [dse_pkg::SYMBOL_W-1:0] in_sym;
    logic [SW-1:0]                in_next;
    logic                         in_acc;
    logic                         s_acc;

    assign in_func  = s_tuser;
    assign in_state = s_tdata[3:0];
    assign in_sym   = s_tdata[6:4];
    assign in_next  = s_tdata[10:7];
    assign in_acc   = s_tdata[11];
    assign s_acc    = s_tvalid & s_tready;

    // Registers
    logic [3:0]                          state_reg, state_next;
    logic [CNT_W-1:0]                    n_reg, n_next;
    logic [SYMC_W-1:0]                   m_reg, m_next;
    logic [ROW_W-1:0]                    i_reg, i_next;
    logic [ROW_W-1:0]                    j_reg, j_next;
    logic [SYM_W-1:0]                    u_reg, u_next;
    logic [ROW_W-1:0]                    hi_reg, hi_next;
    logic [ROW_W-1:0]                    lo_reg, lo_next;
    logic [STATE_LIMIT-1:0]              work_reg, work_next;
    logic                                changed_reg, changed_next;
    logic [MAX_STATES-1:0]               acc_reg, acc_next;
    logic [dse_pkg::STATE_COUNT_W-1:0]   state_count_reg, state_count_next;
    logic [dse_pkg::SYMBOL_COUNT_W-1:0]  symbol_count_reg, symbol_count_next;
    logic [dse_pkg::M_TDATA_W-1:0]       m_tdata_reg, m_tdata_next;
    logic                                m_tlast_reg, m_tlast_next;
    logic                                m_tvalid_reg, m_tvalid_next;

    // Memory ports
    logic                   tr_we;
    logic [TA_W-1:0]        tr_wa;
    logic [TA_W-1:0]        tr_ra0;
    logic [TA_W-1:0]        tr_ra1;
    logic [SW-1:0]          tr_rd0;
    logic [SW-1:0]          tr_rd1;
    logic                   row_we;
    logic [ROW_W-1:0]       row_wa;
    logic [STATE_LIMIT-1:0] row_wd;
    logic [ROW_W-1:0]       row_ra;
    logic [STATE_LIMIT-1:0] row_rd;

    // Helpers
    logic [CNT_W-1:0]       n_clamp;
    logic [SYMC_W-1:0]      m_clamp;
    logic                   last_i;
    logic                   last_j;
    logic                   last_u;
    logic [STATE_LIMIT-1:0] init_row;
    logic                   pair_live;
    logic [SW-1:0]          succ_hi;
    logic [SW-1:0]          succ_lo;
    logic                   succ_hit;
    logic [ROW_W-1:0]       rep;

    // Transition loads write straight into the table from the input item
    assign tr_we  = s_acc && (in_func == dse_pkg::FUNC_LOAD_TRANS) &&
                    (int'(in_state) < MAX_STATES) && (int'(in_sym) < MAX_SYMBOLS);
    assign tr_wa  = {ST_W'(in_state), SYM_W'(in_sym)};
    assign tr_ra0 = {ST_W'(i_reg), u_reg};
    assign tr_ra1 = {ST_W'(j_reg), u_reg};

    dse_trans_mem #(
        .ADDR_W (TA_W),
        .DEPTH  (T_DEPTH),
        .DATA_W (SW)
    ) u_trans_mem (
        .aclk (aclk),
        .we   (tr_we),
        .wa   (tr_wa),
        .wd   (in_next),
        .ra0  (tr_ra0),
        .ra1  (tr_ra1),
        .rd0  (tr_rd0),
        .rd1  (tr_rd1)
    );

    dse_row_mem #(
        .ADDR_W (ROW_W),
        .DEPTH  (STATE_LIMIT),
        .DATA_W (STATE_LIMIT)
    ) u_row_mem (
        .aclk (aclk),
        .we   (row_we),
        .wa   (row_wa),
        .wd   (row_wd),
        .ra   (row_ra),
        .rd   (row_rd)
    );

    // Clamp the configured counts at start
    always_comb begin
        if (state_count_reg == '0) begin
            n_clamp = CNT_W'(1);
        end else if (int'(state_count_reg) > STATE_LIMIT) begin
            n_clamp = CNT_W'(STATE_LIMIT);
        end else begin
            n_clamp = CNT_W'(state_count_reg);
        end
        if (symbol_count_reg == '0) begin
            m_clamp = SYMC_W'(1);
        end else if (int'(symbol_count_reg) > MAX_SYMBOLS) begin
            m_clamp = SYMC_W'(MAX_SYMBOLS);
        end else begin
            m_clamp = SYMC_W'(symbol_count_reg);
        end
    end

    assign last_i = (CNT_W'(i_reg) + CNT_W'(1)) == n_reg;
    assign last_j = (j_reg + ROW_W'(1)) == i_reg;
    assign last_u = (SYMC_W'(u_reg) + SYMC_W'(1)) == m_reg;

    // Initial row: lower pairs whose accepting flags differ
    always_comb begin
        for (int j = 0; j < STATE_LIMIT; j++) begin
            init_row[j] = (ROW_W'(j) < i_reg) && (acc_reg[j] != acc_reg[ST_W'(i_reg)]);
        end
    end

    // Successor pair: order it, drop equal or inactive states
    assign pair_live = (tr_rd0 != tr_rd1) && (int'(tr_rd0) < int'(n_reg)) &&
                       (int'(tr_rd1) < int'(n_reg));
    assign succ_hi   = (tr_rd0 > tr_rd1) ? tr_rd0 : tr_rd1;
    assign succ_lo   = (tr_rd0 > tr_rd1) ? tr_rd1 : tr_rd0;
    // Forward the row under work; memory holds it only after write-back
    assign succ_hit  = (hi_reg == i_reg) ? work_reg[lo_reg] : row_rd[lo_reg];

    // Representative: least lower state not marked distinct
    always_comb begin
        rep = i_reg;
        for (int j = STATE_LIMIT - 1; j >= 0; j--) begin
            if ((ROW_W'(j) < i_reg) && !row_rd[j]) begin
                rep = ROW_W'(j);
            end
        end
    end

    always_comb begin
        state_next        = state_reg;
        n_next            = n_reg;
        m_next            = m_reg;
        i_next            = i_reg;
        j_next            = j_reg;
        u_next            = u_reg;
        hi_next           = hi_reg;
        lo_next           = lo_reg;
        work_next         = work_reg;
        changed_next      = changed_reg;
        acc_next          = acc_reg;
        state_count_next  = state_count_reg;
        symbol_count_next = symbol_count_reg;
        m_tdata_next      = m_tdata_reg;
        m_tlast_next      = m_tlast_reg;
        m_tvalid_next     = m_tvalid_reg;
        row_we            = 1'b0;
        row_wa            = i_reg;
        row_wd            = work_reg;
        row_ra            = i_reg;

        if (cfg_we) begin
            case (cfg_addr)
                dse_pkg::REG_STATE_COUNT: begin
                    state_count_next = cfg_wdata[dse_pkg::STATE_COUNT_W-1:0];
                end
                dse_pkg::REG_SYMBOL_COUNT: begin
                    symbol_count_next = cfg_wdata[dse_pkg::SYMBOL_COUNT_W-1:0];
                end
                default: begin
                end
            endcase
        end

        case (state_reg)
            S_IDLE: begin
                if (s_acc) begin
                    if ((in_func == dse_pkg::FUNC_LOAD_ACC) &&
                        (int'(in_state) < MAX_STATES)) begin
                        acc_next[ST_W'(in_state)] = in_acc;
                    end else if (in_func == dse_pkg::FUNC_START) begin
                        n_next     = n_clamp;
                        m_next     = m_clamp;
                        i_next     = '0;
                        state_next = S_INIT;
                    end
                end
            end
            S_INIT: begin
                // Write one initial row a cycle; this also clears stale rows
                row_we = 1'b1;
                row_wd = init_row;
                if (last_i) begin
                    changed_next = 1'b0;
                    if (n_reg == CNT_W'(1)) begin
                        i_next     = '0;
                        state_next = S_OUT_RD;
                    end else begin
                        i_next     = ROW_W'(1);
                        state_next = S_ROW_RD;
                    end
                end else begin
                    i_next = i_reg + ROW_W'(1);
                end
            end
            S_ROW_RD: begin
                j_next     = '0;
                u_next     = '0;
                state_next = S_ROW_WT;
            end
            S_ROW_WT: begin
                work_next  = row_rd;
                state_next = S_SYM_RD;
            end
            S_SYM_RD: begin
                // Skip pairs already marked; otherwise the transition reads go out now
                if (work_reg[j_reg]) begin
                    if (last_j) begin
                        state_next = S_ROW_WR;
                    end else begin
                        j_next     = j_reg + ROW_W'(1);
                        u_next     = '0;
                        state_next = S_SYM_RD;
                    end
                end else begin
                    state_next = S_SYM_WT;
                end
            end
            S_SYM_WT: begin
                row_ra  = ROW_W'(succ_hi);
                hi_next = ROW_W'(succ_hi);
                lo_next = ROW_W'(succ_lo);
                if (pair_live) begin
                    state_next = S_DIST_CHK;
                end else if (last_u) begin
                    if (last_j) begin
                        state_next = S_ROW_WR;
                    end else begin
                        j_next     = j_reg + ROW_W'(1);
                        u_next     = '0;
                        state_next = S_SYM_RD;
                    end
                end else begin
                    u_next     = u_reg + SYM_W'(1);
                    state_next = S_SYM_RD;
                end
            end
            S_DIST_CHK: begin
                if (succ_hit) begin
                    work_next[j_reg] = 1'b1;
                    changed_next     = 1'b1;
                end
                if (succ_hit || last_u) begin
                    if (last_j) begin
                        state_next = S_ROW_WR;
                    end else begin
                        j_next     = j_reg + ROW_W'(1);
                        u_next     = '0;
                        state_next = S_SYM_RD;
                    end
                end else begin
                    u_next     = u_reg + SYM_W'(1);
                    state_next = S_SYM_RD;
                end
            end
            S_ROW_WR: begin
                row_we = 1'b1;
                if (last_i) begin
                    if (changed_reg) begin
                        changed_next = 1'b0;
                        i_next       = ROW_W'(1);
                        state_next   = S_ROW_RD;
                    end else begin
                        i_next     = '0;
                        state_next = S_OUT_RD;
                    end
                end else begin
                    i_next     = i_reg + ROW_W'(1);
                    state_next = S_ROW_RD;
                end
            end
            S_OUT_RD: begin
                state_next = S_OUT_WT;
            end
            S_OUT_WT: begin
                m_tdata_next  = {SW'(rep), SW'(i_reg)};
                m_tlast_next  = last_i;
                m_tvalid_next = 1'b1;
                state_next    = S_OUT_HOLD;
            end
            S_OUT_HOLD: begin
                // Hold the result until taken
                if (m_tready) begin
                    m_tvalid_next = 1'b0;
                    if (m_tlast_reg) begin
                        state_next = S_IDLE;
                    end else begin
                        i_next     = i_reg + ROW_W'(1);
                        state_next = S_OUT_RD;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= S_IDLE;
            m_tvalid_reg     <= 1'b0;
            changed_reg      <= 1'b0;
            acc_reg          <= '0;
            state_count_reg  <= dse_pkg::STATE_COUNT_RESET;
            symbol_count_reg <= dse_pkg::SYMBOL_COUNT_RESET;
        end else begin
            state_reg        <= state_next;
            m_tvalid_reg     <= m_tvalid_next;
            changed_reg      <= changed_next;
            acc_reg          <= acc_next;
            state_count_reg  <= state_count_next;
            symbol_count_reg <= symbol_count_next;
        end
    end

    always_ff @(posedge aclk) begin
        n_reg       <= n_next;
        m_reg       <= m_next;
        i_reg       <= i_next;
        j_reg       <= j_next;
        u_reg       <= u_next;
        hi_reg      <= hi_next;
        lo_reg      <= lo_next;
        work_reg    <= work_next;
        m_tdata_reg <= m_tdata_next;
        m_tlast_reg <= m_tlast_next;
    end

    assign s_tready = aresetn && (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

endmodule
